/* hw/rtl/jsp_pkg.sv */
// Shared types, constants and helpers for the Julia set pixel classifier.
// Depends on nothing; every other file in hw/rtl imports it.
package jsp_pkg;

    // Image geometry (powers of two) and iteration count.
    localparam int WIDTH_LOG2  = 11;
    localparam int HEIGHT_LOG2 = 11;
    localparam int WIDTH       = 1 << WIDTH_LOG2;
    localparam int HEIGHT      = 1 << HEIGHT_LOG2;
    localparam int ITERATIONS  = 5;
    localparam int HALF_SPAN   = 4;

    // Q4.28 fixed point.
    localparam int FRAC_BITS = 28;
    localparam int Q_W       = 32;
    localparam int SEED_W    = 31;
    localparam int COORD_W   = 11;

    localparam logic signed [63:0] Q_MAX64 = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN64 = -64'sd2147483648;
    // |z|^2 > 4.0 in Q8.56, compared on a 65-bit unsigned sum.
    localparam logic [64:0] ESC_LIMIT = 65'd4 << (2 * FRAC_BITS);

    // Configuration registers.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_REAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_IMAG = 1'd1;
    localparam logic signed [SEED_W-1:0] SEED_REAL_RST = -31'sd268435456;
    localparam logic signed [SEED_W-1:0] SEED_IMAG_RST = 31'sd0;

    // Map stage, two stages per iteration cell, two stages in the final test.
    localparam int LATENCY    = 2 * ITERATIONS + 3;
    localparam int FIFO_AW    = $clog2(LATENCY + 1);
    localparam int FIFO_DEPTH = 1 << FIFO_AW;
    localparam int CREDITS    = FIFO_DEPTH + 1;
    localparam int CNT_W      = $clog2(CREDITS + 1);

    typedef logic signed [Q_W-1:0] t_q;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        t_q                 re;
        t_q                 im;
        logic               esc;
    } t_cell_data;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               esc;
    } t_result;

    // Clamp a wide signed value into the Q4.28 range.
    function automatic t_q sat_q(input logic signed [63:0] v);
        t_q res;
        if (v > Q_MAX64) begin
            res = Q_MAX64[Q_W-1:0];
        end else if (v < Q_MIN64) begin
            res = Q_MIN64[Q_W-1:0];
        end else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/jsp_iter_cell.sv */
// One iteration cell: escape test on z, then z = z*z + c unless escaped.
// Depends on jsp_pkg.
module jsp_iter_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  jsp_pkg::t_cell_data                i_d,
    input  logic signed [jsp_pkg::SEED_W-1:0]  i_seed_re,
    input  logic signed [jsp_pkg::SEED_W-1:0]  i_seed_im,
    output jsp_pkg::t_cell_data                o_d
);
    import jsp_pkg::*;

    t_q                 w_re;
    t_q                 w_im;
    logic signed [63:0] w_rr;
    logic signed [63:0] w_ii;
    logic signed [63:0] w_ri;

    t_cell_data         r_s1;
    logic [63:0]        r_rr;
    logic [63:0]        r_ii;
    logic signed [63:0] r_ri;

    logic [64:0]        w_mag;
    logic               w_out;
    logic signed [63:0] w_diff;
    logic signed [63:0] w_re_sum;
    logic signed [63:0] w_im_sum;
    t_cell_data         n_s2;
    t_cell_data         r_s2;

    // Stage 1: squares and cross product, exact in Q8.56.
    assign w_re = i_d.re;
    assign w_im = i_d.im;
    assign w_rr = w_re * w_re;
    assign w_ii = w_im * w_im;
    assign w_ri = w_re * w_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= i_d.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1.x   <= i_d.x;
        r_s1.y   <= i_d.y;
        r_s1.re  <= i_d.re;
        r_s1.im  <= i_d.im;
        r_s1.esc <= i_d.esc;
        r_rr     <= $unsigned(w_rr);
        r_ii     <= $unsigned(w_ii);
        r_ri     <= w_ri;
    end

    // Stage 2: escape test, floor back to Q4.28, add seed, saturate; hold z once escaped.
    always_comb begin
        w_mag    = {1'b0, r_rr} + {1'b0, r_ii};
        w_out    = w_mag > ESC_LIMIT;
        w_diff   = $signed(r_rr) - $signed(r_ii);
        w_re_sum = (w_diff >>> FRAC_BITS) + 64'(i_seed_re);
        // floor(2*ri / 2^28) is ri shifted one place less
        w_im_sum = (r_ri >>> (FRAC_BITS - 1)) + 64'(i_seed_im);
        n_s2       = r_s1;
        n_s2.esc   = r_s1.esc | w_out;
        if (!n_s2.esc) begin
            n_s2.re = sat_q(w_re_sum);
            n_s2.im = sat_q(w_im_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= n_s2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2.x   <= n_s2.x;
        r_s2.y   <= n_s2.y;
        r_s2.re  <= n_s2.re;
        r_s2.im  <= n_s2.im;
        r_s2.esc <= n_s2.esc;
    end

    assign o_d = r_s2;

endmodule

/* hw/rtl/jsp_final_cell.sv */
// Closing cell: escape test on the z left after the last iteration.
// Depends on jsp_pkg.
module jsp_final_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  jsp_pkg::t_cell_data  i_d,
    output logic                 o_valid,
    output jsp_pkg::t_result     o_res
);
    import jsp_pkg::*;

    t_q                 w_re;
    t_q                 w_im;
    logic signed [63:0] w_rr;
    logic signed [63:0] w_ii;
    logic               r_s1_valid;
    t_result            r_s1;
    logic [63:0]        r_rr;
    logic [63:0]        r_ii;
    logic [64:0]        w_mag;
    logic               r_valid;
    t_result            r_res;

    assign w_re = i_d.re;
    assign w_im = i_d.im;
    assign w_rr = w_re * w_re;
    assign w_ii = w_im * w_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_s1_valid <= i_d.valid;
            r_valid    <= r_s1_valid;
        end
    end

    assign w_mag = {1'b0, r_rr} + {1'b0, r_ii};

    always_ff @(posedge i_clk) begin
        r_s1.x    <= i_d.x;
        r_s1.y    <= i_d.y;
        r_s1.esc  <= i_d.esc;
        r_rr      <= $unsigned(w_rr);
        r_ii      <= $unsigned(w_ii);
        r_res.x   <= r_s1.x;
        r_res.y   <= r_s1.y;
        r_res.esc <= r_s1.esc | (w_mag > ESC_LIMIT);
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* hw/rtl/jsp_out_fifo.sv */
// Result queue with registered read into the output register.
// Depends on jsp_pkg.
module jsp_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  jsp_pkg::t_result  i_wr_data,
    output logic              o_valid,
    output jsp_pkg::t_result  o_data,
    input  logic              i_stall
);
    import jsp_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wptr;
    logic [FIFO_AW-1:0]   r_rptr;
    logic [FIFO_AW:0]     r_fill;
    logic                 r_out_valid;
    t_result              r_out;
    logic                 w_load;

    // refill the output register when it is empty or being taken
    assign w_load = (r_fill != '0) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wr_data;
        end
        if (w_load) begin
            r_out <= r_mem[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_load) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_fill      <= r_fill + (FIFO_AW+1)'(i_wr) - (FIFO_AW+1)'(w_load);
            r_out_valid <= w_load || (r_out_valid && i_stall);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* hw/rtl/julia_set_pixel_classifier.sv */
// An accepted pixel passes the map stage, the iteration cells and the final test, then waits in the result queue.
// Throughput: one pixel per cycle while o_stall is low, set by the chain of iteration cells (two stages each).
// Up to FIFO_DEPTH+1 results may be outstanding before o_stall rises (17 as built).
// Reset (synchronous, i_rst_n low): empty pipeline and queue, seed = -1.0 + 0i.
// The configuration port is always ready; write it only while the block is idle.
// Depends on jsp_pkg, jsp_iter_cell, jsp_final_cell and jsp_out_fifo.
module julia_set_pixel_classifier (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // pixel input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [jsp_pkg::COORD_W-1:0]           i_pixel_x,
    input  logic [jsp_pkg::COORD_W-1:0]           i_pixel_y,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [jsp_pkg::COORD_W-1:0]           o_out_x,
    output logic [jsp_pkg::COORD_W-1:0]           o_out_y,
    output logic                                  o_escaped,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [jsp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [jsp_pkg::SEED_W-1:0]            i_cfg_data
);
    import jsp_pkg::*;

    logic signed [SEED_W-1:0] r_seed_re;
    logic signed [SEED_W-1:0] r_seed_im;

    logic                     w_accept;
    logic                     w_deliver;
    logic [CNT_W-1:0]         r_cnt;

    logic signed [13:0]       w_vx;
    logic signed [13:0]       w_vy;
    logic signed [63:0]       w_num_x;
    logic signed [63:0]       w_num_y;
    t_cell_data               n_map;
    t_cell_data               r_map;

    t_cell_data               w_link [ITERATIONS+1];
    logic                     w_fin_valid;
    t_result                  w_fin;
    t_result                  w_out;

    // Configuration: the port never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_re <= SEED_REAL_RST;
            r_seed_im <= SEED_IMAG_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SEED_REAL: r_seed_re <= i_cfg_data;
                REG_SEED_IMAG: r_seed_im <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Credit count: every accepted transaction owns a queue slot until delivered,
    // so the free-running cell chain can never overrun the result queue.
    assign w_accept  = i_valid && !o_stall;
    assign w_deliver = o_valid && !i_stall;
    assign o_stall   = (r_cnt == CNT_W'(CREDITS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CNT_W'(w_accept) - CNT_W'(w_deliver);
        end
    end

    // Map stage: coordinate = HALF_SPAN*(2p - size)/size in Q4.28. The size is a power
    // of two, so the division is exact and reduces to a left shift.
    assign w_vx    = $signed({2'b00, i_pixel_x, 1'b0}) - $signed(14'(WIDTH));
    assign w_vy    = $signed({2'b00, i_pixel_y, 1'b0}) - $signed(14'(HEIGHT));
    assign w_num_x = (64'(w_vx) * 64'(HALF_SPAN)) <<< (FRAC_BITS - WIDTH_LOG2);
    assign w_num_y = (64'(w_vy) * 64'(HALF_SPAN)) <<< (FRAC_BITS - HEIGHT_LOG2);

    always_comb begin
        n_map.valid = w_accept;
        n_map.x     = i_pixel_x;
        n_map.y     = i_pixel_y;
        n_map.re    = sat_q(w_num_x);
        n_map.im    = sat_q(w_num_y);
        n_map.esc   = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map.valid <= 1'b0;
        end else begin
            r_map.valid <= n_map.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_map.x   <= n_map.x;
        r_map.y   <= n_map.y;
        r_map.re  <= n_map.re;
        r_map.im  <= n_map.im;
        r_map.esc <= n_map.esc;
    end

    // Chain of iteration cells: each advances every cycle, handing z to its neighbour.
    assign w_link[0] = r_map;

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
        jsp_iter_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_d       (w_link[g]),
            .i_seed_re (r_seed_re),
            .i_seed_im (r_seed_im),
            .o_d       (w_link[g+1])
        );
    end

    // Final escape test after the last iteration.
    jsp_final_cell u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (w_link[ITERATIONS]),
        .o_valid (w_fin_valid),
        .o_res   (w_fin)
    );

    // Hold results until the downstream side takes them.
    jsp_out_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_fin_valid),
        .i_wr_data (w_fin),
        .o_valid   (o_valid),
        .o_data    (w_out),
        .i_stall   (i_stall)
    );

    assign o_out_x   = w_out.x;
    assign o_out_y   = w_out.y;
    assign o_escaped = w_out.esc;

    // Credits never exceed the queue plus output register.
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CREDITS))
        else $error("credit count above capacity");

    // A result on the port must be backed by an outstanding transaction.
    a_valid_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_cnt != '0))
        else $error("result shown with no outstanding transaction");

    // Every accepted pixel leaves the cell chain a fixed latency later.
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY w_fin_valid)
        else $error("pixel lost in the cell chain");

    // Something finishing the chain always has a credit behind it.
    a_fin_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_valid |-> (r_cnt != '0))
        else $error("result finished with no outstanding transaction");

endmodule
